@@ hdl/rbts_pkg.sv @@
// ----------------------------------------------------------------------------
// rbts_pkg
// Shared types and constants for the rotated blit tile splitter.
// ----------------------------------------------------------------------------
package rbts_pkg;
    localparam int CW = 14;
    localparam int MW = 3;
    localparam int IN_W = 8 * CW + MW;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 8 * CW + MW;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam int MAX_TILES = 64;

    localparam logic [MW-1:0] MODE_NONE   = 3'd0;
    localparam logic [MW-1:0] MODE_ROT90  = 3'd1;
    localparam logic [MW-1:0] MODE_ROT180 = 3'd2;
    localparam logic [MW-1:0] MODE_ROT270 = 3'd3;
    localparam logic [MW-1:0] MODE_HFLIP  = 3'd4;
    localparam logic [MW-1:0] MODE_VFLIP  = 3'd5;
    localparam logic [MW-1:0] MODE_ULLR   = 3'd6;
    localparam logic [MW-1:0] MODE_URLL   = 3'd7;

    typedef logic [CW-1:0] coord_t;
endpackage

@@ hdl/rotated_blit_tile_splitter.sv @@
// ----------------------------------------------------------------------------
// rotated_blit_tile_splitter
// Splits a rotated blit request into destination tiles with scaled source crops.
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | one blit request (rectangles and mode)
// m_axis  | out | one crop pair per tile, tlast on the final tile
//
// Each tile runs four multiply-divides through one shared restoring divider,
// one quotient bit per cycle over 2 * CW bits, once the request is checked.
// Whole-crop and rejected requests are answered from the check state.
// Reset returns the sequencer to idle; no request is held.
// A stalled result holds the sequencer until it is taken.
module rotated_blit_tile_splitter #(
    parameter int TILE_SIZE   = 1024,
    parameter int COORD_LIMIT = 8192
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // src_left, src_top, src_right, src_bottom, dst_left, dst_top,
    // dst_right, dst_bottom, rotation
    input  logic [rbts_pkg::IN_BYTES_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // in_crop_x, in_crop_y, in_crop_w, in_crop_h, out_crop_x, out_crop_y,
    // out_crop_w, out_crop_h, rotate_mode
    output logic [rbts_pkg::OUT_BYTES_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // bad_region
    output logic                                m_axis_tuser
);
    import rbts_pkg::*;

    localparam int PW = 2 * CW;
    localparam int QW = CW;
    localparam logic [CW-1:0] TILE_C = CW'(TILE_SIZE);
    localparam logic [16:0] LIMIT_C = 17'(COORD_LIMIT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_CNT  = 3'd5;

    logic [2:0] state_reg, state_next;
    coord_t c_reg [8];
    logic [MW-1:0] mode_reg;
    coord_t iw_reg, ih_reg, ow_reg, oh_reg;
    coord_t ox_reg, oy_reg;
    logic [1:0] op_reg;
    logic [PW-1:0] num_reg;
    logic [CW-1:0] rem_reg;
    logic [$clog2(PW+1)-1:0] bit_reg;
    logic [PW-1:0] quo_reg;
    coord_t res_reg [4];
    logic [OUT_W-1:0] out_reg;
    logic last_reg, bad_reg, vld_reg;

    logic swap, mx, my;
    always_comb begin
        swap = 1'b0; mx = 1'b0; my = 1'b0;
        unique case (mode_reg)
            MODE_ROT90:  begin swap = 1'b1; my = 1'b1; end
            MODE_ROT270: begin swap = 1'b1; mx = 1'b1; end
            MODE_HFLIP:  mx = 1'b1;
            MODE_VFLIP:  my = 1'b1;
            MODE_ULLR:   swap = 1'b1;
            default:     begin swap = 1'b1; mx = 1'b1; my = 1'b1; end
        endcase
    end

    coord_t tw, th;
    logic xl, yl;
    assign xl = ({1'b0, ox_reg} + {1'b0, TILE_C}) >= {1'b0, ow_reg};
    assign yl = ({1'b0, oy_reg} + {1'b0, TILE_C}) >= {1'b0, oh_reg};
    assign tw = xl ? ow_reg - ox_reg : TILE_C;
    assign th = yl ? oh_reg - oy_reg : TILE_C;

    // operand selection for the shared multiply-divide
    coord_t ma, mb, dv;
    always_comb begin
        ma = iw_reg; mb = tw; dv = ow_reg;
        case ({swap, op_reg})
            3'b000: begin ma = iw_reg; mb = tw;     dv = ow_reg; end
            3'b001: begin ma = ih_reg; mb = th;     dv = oh_reg; end
            3'b010: begin ma = iw_reg; mb = ox_reg; dv = ow_reg; end
            3'b011: begin ma = ih_reg; mb = oy_reg; dv = oh_reg; end
            3'b100: begin ma = iw_reg; mb = th;     dv = oh_reg; end
            3'b101: begin ma = ih_reg; mb = tw;     dv = ow_reg; end
            3'b110: begin ma = iw_reg; mb = oy_reg; dv = oh_reg; end
            default: begin ma = ih_reg; mb = ox_reg; dv = ow_reg; end
        endcase
    end

    logic [CW+1:0] trial;
    logic [CW:0] rsh;
    assign rsh = {rem_reg, num_reg[PW-1]};
    assign trial = {1'b0, rsh} - {2'b0, dv};

    logic bad_in;
    logic [2*CW+1:0] ntiles;
    logic [CW:0] nx, ny;
    assign nx = (CW+1)'(({1'b0, ow_reg} + {1'b0, TILE_C} - 1'b1) / TILE_SIZE);
    assign ny = (CW+1)'(({1'b0, oh_reg} + {1'b0, TILE_C} - 1'b1) / TILE_SIZE);
    assign ntiles = (2*CW+2)'(nx) * (2*CW+2)'(ny);

    coord_t sx, sy;
    assign sx = c_reg[0] + (mx ? iw_reg - res_reg[0] - res_reg[2] : res_reg[2]);
    assign sy = c_reg[1] + (my ? ih_reg - res_reg[1] - res_reg[3] : res_reg[3]);

    always_comb begin
        bad_in = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if ({3'b0, c_reg[i]} > LIMIT_C) bad_in = 1'b1;
        end
        if (c_reg[2] <= c_reg[0] || c_reg[3] <= c_reg[1] ||
            c_reg[6] <= c_reg[4] || c_reg[7] <= c_reg[5]) bad_in = 1'b1;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !vld_reg;
    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata = {{(OUT_BYTES_W-OUT_W){1'b0}}, out_reg};
    assign m_axis_tlast = last_reg;
    assign m_axis_tuser = bad_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = S_CHK;
            S_CHK:  state_next = S_IDLE;
            S_MUL:  state_next = S_DIV;
            S_DIV:  if (bit_reg == 0) state_next = (op_reg == 2'd3) ? S_OUT : S_MUL;
            S_OUT:  if (!vld_reg) state_next = S_CNT;
            S_CNT:  state_next = (xl && yl) ? S_IDLE : S_MUL;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_CHK && !bad_in && mode_reg != MODE_NONE &&
            mode_reg != MODE_ROT180 && ntiles <= (2*CW+2)'(MAX_TILES))
            state_next = S_MUL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (vld_reg && m_axis_tready) vld_reg <= 1'b0;
            if (state_reg == S_CHK && state_next == S_IDLE) vld_reg <= 1'b1;
            if (state_reg == S_OUT && !vld_reg) vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    for (int i = 0; i < 8; i++) c_reg[i] <= s_axis_tdata[i*CW +: CW];
                    mode_reg <= s_axis_tdata[8*CW +: MW];
                    iw_reg <= s_axis_tdata[2*CW +: CW] - s_axis_tdata[0 +: CW];
                    ih_reg <= s_axis_tdata[3*CW +: CW] - s_axis_tdata[CW +: CW];
                    ow_reg <= s_axis_tdata[6*CW +: CW] - s_axis_tdata[4*CW +: CW];
                    oh_reg <= s_axis_tdata[7*CW +: CW] - s_axis_tdata[5*CW +: CW];
                end
                ox_reg <= '0; oy_reg <= '0; op_reg <= '0;
            end
            S_CHK: begin
                last_reg <= 1'b1;
                bad_reg <= 1'b1;
                out_reg <= {mode_reg, {(8*CW){1'b0}}};
                if (!bad_in && (mode_reg == MODE_NONE || mode_reg == MODE_ROT180)) begin
                    bad_reg <= 1'b0;
                    out_reg <= {mode_reg, oh_reg, ow_reg, c_reg[5], c_reg[4],
                                ih_reg, iw_reg, c_reg[1], c_reg[0]};
                end
            end
            S_MUL: begin
                num_reg <= PW'(ma) * PW'(mb);
                rem_reg <= '0;
                bit_reg <= ($clog2(PW+1))'(PW);
            end
            S_DIV: begin
                if (bit_reg != 0) begin
                    bit_reg <= bit_reg - 1'b1;
                    num_reg <= {num_reg[PW-2:0], 1'b0};
                    if (!trial[CW+1]) begin
                        rem_reg <= trial[CW-1:0];
                        quo_reg <= {quo_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rsh[CW-1:0];
                        quo_reg <= {quo_reg[PW-2:0], 1'b0};
                    end
                end else begin
                    res_reg[op_reg] <= quo_reg[QW-1:0];
                    op_reg <= op_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (!vld_reg) begin
                    bad_reg <= 1'b0;
                    last_reg <= xl && yl;
                    out_reg <= {mode_reg, th, tw, c_reg[5] + oy_reg,
                                c_reg[4] + ox_reg, res_reg[1], res_reg[0], sy, sx};
                end
            end
            S_CNT: begin
                if (xl) begin
                    ox_reg <= '0;
                    oy_reg <= oy_reg + TILE_C;
                end else ox_reg <= ox_reg + TILE_C;
            end
            default: ;
        endcase
    end
endmodule
